/* rtl/safety_packet_acceptance_check_macros.svh */
// assertion macros for the packet acceptance check
`ifndef SAFETY_PACKET_ACCEPTANCE_CHECK_MACROS_SVH
`define SAFETY_PACKET_ACCEPTANCE_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define SAPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// property checked on every clock edge, reset included
`define SAPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SAPC_ASSERT(label, prop, msg)
`define SAPC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/sapc_pkg.sv */
`timescale 1ns / 1ps

package sapc_pkg;

    localparam int unsigned KIND_W     = 3;
    localparam int unsigned VERD_W     = 3;
    localparam int unsigned ID_W       = 32;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned WIN_W      = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // sequence range limit is this many send windows
    localparam int unsigned RANGE_FACTOR = 10;
    localparam int unsigned LIMIT_W      = WIN_W + 4;

    // packet kinds
    localparam logic [KIND_W-1:0] KIND_CONNREQ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CONNRESP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RETRREQ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RETRRESP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISCREQ   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DATA      = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RETRDATA  = 3'd7;

    // verdict codes
    localparam logic [VERD_W-1:0] VERD_ACCEPT   = 3'd0;
    localparam logic [VERD_W-1:0] VERD_CONNREQ  = 3'd1;
    localparam logic [VERD_W-1:0] VERD_CONNRESP = 3'd2;
    localparam logic [VERD_W-1:0] VERD_CHECKSUM = 3'd3;
    localparam logic [VERD_W-1:0] VERD_ADDRESS  = 3'd4;
    localparam logic [VERD_W-1:0] VERD_SEQ      = 3'd5;
    localparam logic [VERD_W-1:0] VERD_CONF_SEQ = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ID    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ID     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_WINDOW = 8'd3;

    localparam logic [TIME_W-1:0] MAX_DELAY_RST   = 32'd1800;
    localparam logic [WIN_W-1:0]  SEND_WINDOW_RST = 16'd20;

    typedef struct packed {
        logic [KIND_W-1:0] packet_kind;
        logic              checksum_ok;
        logic [ID_W-1:0]   sender;
        logic [ID_W-1:0]   receiver;
        logic [SEQ_W-1:0]  pkt_seq;
        logic [SEQ_W-1:0]  pkt_conf_seq;
        logic [TIME_W-1:0] pkt_conf_time;
        logic [SEQ_W-1:0]  expected_seq;
        logic [SEQ_W-1:0]  last_conf_seq;
        logic [SEQ_W-1:0]  next_send_seq;
        logic [TIME_W-1:0] last_conf_time;
        logic              clear_counts;
    } t_pkt;

    typedef struct packed {
        logic [ID_W-1:0]   local_id;
        logic [ID_W-1:0]   peer_id;
        logic [TIME_W-1:0] max_delay;
        logic [WIN_W-1:0]  send_window;
    } t_cfg;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic              ids_ok;
        logic              seq_range_ok;
        logic              conf_seq_ok;
        logic              seq_in_order;
        logic              time_in_order;
        logic              all_ok;
    } t_chk;

endpackage

/* rtl/sapc_check.sv */
`timescale 1ns / 1ps

module sapc_check (
    input  sapc_pkg::t_pkt i_pkt,
    input  sapc_pkg::t_cfg i_cfg,
    output sapc_pkg::t_chk o_chk
);
    import sapc_pkg::*;

    logic [LIMIT_W-1:0] w_limit;
    logic [SEQ_W-1:0]   w_seq_diff;
    logic [SEQ_W-1:0]   w_cs_diff;
    logic [SEQ_W-1:0]   w_cs_span;
    logic [TIME_W-1:0]  w_time_diff;
    logic               w_handoff_range;
    logic               w_ids_ok;
    logic               w_range_ok;
    logic               w_cs_ok;
    logic               w_sn_ok;
    logic               w_ts_ok;

    // window times ten, fits in twenty bits
    assign w_limit     = LIMIT_W'(i_cfg.send_window) * LIMIT_W'(RANGE_FACTOR);
    assign w_seq_diff  = i_pkt.pkt_seq - i_pkt.expected_seq;
    assign w_cs_diff   = i_pkt.pkt_conf_seq - i_pkt.last_conf_seq;
    assign w_cs_span   = i_pkt.next_send_seq - i_pkt.last_conf_seq;
    assign w_time_diff = i_pkt.pkt_conf_time - i_pkt.last_conf_time;

    assign w_ids_ok = (i_pkt.sender == i_cfg.peer_id) && (i_pkt.receiver == i_cfg.local_id);

    assign w_handoff_range = (i_pkt.packet_kind == KIND_CONNREQ)
                          || (i_pkt.packet_kind == KIND_CONNRESP)
                          || (i_pkt.packet_kind == KIND_RETRRESP);

    assign w_range_ok = w_handoff_range
                     || ((i_pkt.pkt_seq >= i_pkt.expected_seq)
                         && (w_seq_diff <= SEQ_W'(w_limit)));

    always_comb begin
        case (i_pkt.packet_kind)
            KIND_CONNREQ:  w_cs_ok = (i_pkt.pkt_conf_seq == '0);
            KIND_CONNRESP: w_cs_ok = (i_pkt.pkt_conf_seq == (i_pkt.next_send_seq - 32'd1));
            default:       w_cs_ok = (i_pkt.pkt_conf_seq >= i_pkt.last_conf_seq)
                                  && (w_cs_diff < w_cs_span);
        endcase
    end

    always_comb begin
        case (i_pkt.packet_kind)
            KIND_RETRREQ, KIND_HEARTBEAT, KIND_DATA, KIND_RETRDATA:
                w_sn_ok = (i_pkt.pkt_seq == i_pkt.expected_seq);
            default:
                w_sn_ok = 1'b1;
        endcase
    end

    always_comb begin
        case (i_pkt.packet_kind)
            KIND_HEARTBEAT, KIND_DATA, KIND_RETRDATA:
                // no timestamp seen yet passes
                w_ts_ok = (i_pkt.last_conf_time == '0)
                       || ((i_pkt.pkt_conf_time >= i_pkt.last_conf_time)
                           && (w_time_diff < i_cfg.max_delay));
            default:
                w_ts_ok = 1'b1;
        endcase
    end

    always_comb begin
        o_chk.ids_ok        = w_ids_ok;
        o_chk.seq_range_ok  = w_range_ok;
        o_chk.conf_seq_ok   = w_cs_ok;
        o_chk.seq_in_order  = w_sn_ok;
        o_chk.time_in_order = w_ts_ok;
        o_chk.all_ok        = i_pkt.checksum_ok && w_ids_ok && w_range_ok
                           && w_cs_ok && w_sn_ok && w_ts_ok;
        if (i_pkt.packet_kind == KIND_CONNREQ) begin
            o_chk.verdict = VERD_CONNREQ;
        end else if (i_pkt.packet_kind == KIND_CONNRESP) begin
            o_chk.verdict = VERD_CONNRESP;
        end else if (!i_pkt.checksum_ok) begin
            o_chk.verdict = VERD_CHECKSUM;
        end else if (!w_ids_ok) begin
            o_chk.verdict = VERD_ADDRESS;
        end else if (!w_range_ok) begin
            o_chk.verdict = VERD_SEQ;
        end else if (!w_cs_ok) begin
            o_chk.verdict = VERD_CONF_SEQ;
        end else begin
            o_chk.verdict = VERD_ACCEPT;
        end
    end

endmodule

/* rtl/safety_packet_acceptance_check.sv */
// an input beat reaches the result beat through the input register and then the result register
// throughput: one packet header per cycle while the result channel is not stalled, set by the single check stage
// the input register can still take a header while a result beat waits
// reset: synchronous active low; clears valids and error counters, and loads
// the register defaults (ids 0, max delay 1800, send window 20)
`timescale 1ns / 1ps
`include "safety_packet_acceptance_check_macros.svh"

module safety_packet_acceptance_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sapc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sapc_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // packet header channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sapc_pkg::KIND_W-1:0]         i_packet_kind,
    input  logic                                i_checksum_ok,
    input  logic [sapc_pkg::ID_W-1:0]           i_sender,
    input  logic [sapc_pkg::ID_W-1:0]           i_receiver,
    input  logic [sapc_pkg::SEQ_W-1:0]          i_pkt_seq,
    input  logic [sapc_pkg::SEQ_W-1:0]          i_pkt_conf_seq,
    input  logic [sapc_pkg::TIME_W-1:0]         i_pkt_conf_time,
    input  logic [sapc_pkg::SEQ_W-1:0]          i_expected_seq,
    input  logic [sapc_pkg::SEQ_W-1:0]          i_last_conf_seq,
    input  logic [sapc_pkg::SEQ_W-1:0]          i_next_send_seq,
    input  logic [sapc_pkg::TIME_W-1:0]         i_last_conf_time,
    input  logic                                i_clear_counts,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sapc_pkg::VERD_W-1:0]         o_verdict,
    output logic                                o_ids_ok,
    output logic                                o_seq_range_ok,
    output logic                                o_conf_seq_ok,
    output logic                                o_seq_in_order,
    output logic                                o_time_in_order,
    output logic                                o_all_ok,
    output logic [sapc_pkg::CNT_W-1:0]          o_checksum_errors,
    output logic [sapc_pkg::CNT_W-1:0]          o_address_errors,
    output logic [sapc_pkg::CNT_W-1:0]          o_seq_errors,
    output logic [sapc_pkg::CNT_W-1:0]          o_conf_seq_errors
);
    import sapc_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input stage
    logic r_s1_valid;
    t_pkt r_pkt;

    // result stage
    logic r_out_valid;
    t_chk r_chk;
    t_chk w_chk;

    // error counters; they only move when a beat enters the result stage,
    // so they read directly as the counts after the packet on the output
    logic [CNT_W-1:0] r_csum_cnt, n_csum_cnt;
    logic [CNT_W-1:0] r_addr_cnt, n_addr_cnt;
    logic [CNT_W-1:0] r_seq_cnt,  n_seq_cnt;
    logic [CNT_W-1:0] r_conf_cnt, n_conf_cnt;

    logic       w_in_fire;
    logic       w_advance;
    logic [3:0] w_inc;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_id    <= '0;
            r_cfg.peer_id     <= '0;
            r_cfg.max_delay   <= MAX_DELAY_RST;
            r_cfg.send_window <= SEND_WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOCAL_ID:    r_cfg.local_id    <= i_cfg_data[ID_W-1:0];
                CFG_PEER_ID:     r_cfg.peer_id     <= i_cfg_data[ID_W-1:0];
                CFG_MAX_DELAY:   r_cfg.max_delay   <= i_cfg_data[TIME_W-1:0];
                CFG_SEND_WINDOW: r_cfg.send_window <= i_cfg_data[WIN_W-1:0];
                default:         ; // unknown index, write dropped
            endcase
        end
    end

    // the input stage moves on when the result stage is empty or being drained
    assign w_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_advance;
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_pkt.packet_kind    <= i_packet_kind;
            r_pkt.checksum_ok    <= i_checksum_ok;
            r_pkt.sender         <= i_sender;
            r_pkt.receiver       <= i_receiver;
            r_pkt.pkt_seq        <= i_pkt_seq;
            r_pkt.pkt_conf_seq   <= i_pkt_conf_seq;
            r_pkt.pkt_conf_time  <= i_pkt_conf_time;
            r_pkt.expected_seq   <= i_expected_seq;
            r_pkt.last_conf_seq  <= i_last_conf_seq;
            r_pkt.next_send_seq  <= i_next_send_seq;
            r_pkt.last_conf_time <= i_last_conf_time;
            r_pkt.clear_counts   <= i_clear_counts;
        end
    end

    // all header checks in one combinational pass
    sapc_check u_check (
        .i_pkt (r_pkt),
        .i_cfg (r_cfg),
        .o_chk (w_chk)
    );

    // at most one of these per beat: the first failing check owns the count
    assign w_inc[0] = w_advance && (w_chk.verdict == VERD_CHECKSUM);
    assign w_inc[1] = w_advance && (w_chk.verdict == VERD_ADDRESS);
    assign w_inc[2] = w_advance && (w_chk.verdict == VERD_SEQ);
    assign w_inc[3] = w_advance && (w_chk.verdict == VERD_CONF_SEQ);

    always_comb begin
        n_csum_cnt = r_csum_cnt;
        n_addr_cnt = r_addr_cnt;
        n_seq_cnt  = r_seq_cnt;
        n_conf_cnt = r_conf_cnt;
        if (w_advance) begin
            // clear comes first, then this packet's increment
            if (r_pkt.clear_counts) begin
                n_csum_cnt = '0;
                n_addr_cnt = '0;
                n_seq_cnt  = '0;
                n_conf_cnt = '0;
            end
            if (w_inc[0]) begin
                n_csum_cnt = sat_inc(n_csum_cnt);
            end
            if (w_inc[1]) begin
                n_addr_cnt = sat_inc(n_addr_cnt);
            end
            if (w_inc[2]) begin
                n_seq_cnt = sat_inc(n_seq_cnt);
            end
            if (w_inc[3]) begin
                n_conf_cnt = sat_inc(n_conf_cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_csum_cnt  <= '0;
            r_addr_cnt  <= '0;
            r_seq_cnt   <= '0;
            r_conf_cnt  <= '0;
        end else begin
            r_csum_cnt <= n_csum_cnt;
            r_addr_cnt <= n_addr_cnt;
            r_seq_cnt  <= n_seq_cnt;
            r_conf_cnt <= n_conf_cnt;
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_chk <= w_chk;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_verdict         = r_chk.verdict;
    assign o_ids_ok          = r_chk.ids_ok;
    assign o_seq_range_ok    = r_chk.seq_range_ok;
    assign o_conf_seq_ok     = r_chk.conf_seq_ok;
    assign o_seq_in_order    = r_chk.seq_in_order;
    assign o_time_in_order   = r_chk.time_in_order;
    assign o_all_ok          = r_chk.all_ok;
    assign o_checksum_errors = r_csum_cnt;
    assign o_address_errors  = r_addr_cnt;
    assign o_seq_errors      = r_seq_cnt;
    assign o_conf_seq_errors = r_conf_cnt;

    // a single packet never bumps two counters
    `SAPC_ASSERT(a_one_inc, $onehot0(w_inc), "more than one error counter bumped")
    // counts seen with a stalled result stay put until it is taken
    `SAPC_ASSERT(a_cnt_hold, r_out_valid && !i_out_ready |=> $stable(r_csum_cnt) && $stable(r_addr_cnt) && $stable(r_seq_cnt) && $stable(r_conf_cnt), "error counts moved under a stalled result")
    // a full input stage only takes a new beat when it hands its own one on
    `SAPC_ASSERT(a_no_overrun, w_in_fire && r_s1_valid |-> w_advance, "input stage overwritten")

endmodule

/* test/tb_safety_packet_acceptance_check.sv */
`timescale 1ns / 1ps

module tb_safety_packet_acceptance_check;
    import sapc_pkg::*;

    // cycles with no beat on any channel before the run is declared hung
    localparam int unsigned QUIET_LIMIT   = 1000;
    // length of the forced receiver hold-off
    localparam int unsigned STALL_CYCLES  = 80;
    // two register stages, plus margin
    localparam int unsigned SETTLE_CYCLES = 4;
    // keep the log short when the block is badly broken
    localparam int unsigned PRINT_CAP     = 100;

    // everything one result beat carries
    typedef struct packed {
        t_chk             chk;
        logic [CNT_W-1:0] checksum_errors;
        logic [CNT_W-1:0] address_errors;
        logic [CNT_W-1:0] seq_errors;
        logic [CNT_W-1:0] conf_seq_errors;
    } t_outcome;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration write channel
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // packet header channel
    logic in_valid = 1'b0;
    logic in_ready;
    t_pkt pkt_drv  = '0;

    // result channel
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [VERD_W-1:0] verdict;
    logic              ids_ok;
    logic              seq_range_ok;
    logic              conf_seq_ok;
    logic              seq_in_order;
    logic              time_in_order;
    logic              all_ok;
    logic [CNT_W-1:0]  checksum_errors;
    logic [CNT_W-1:0]  address_errors;
    logic [CNT_W-1:0]  seq_errors;
    logic [CNT_W-1:0]  conf_seq_errors;

    // shadow of the register file and of the error counters
    t_cfg cfg_model = '{local_id: '0, peer_id: '0, max_delay: MAX_DELAY_RST,
                        send_window: SEND_WINDOW_RST};
    logic [CNT_W-1:0] csum_err_seen = '0;
    logic [CNT_W-1:0] addr_err_seen = '0;
    logic [CNT_W-1:0] seq_err_seen  = '0;
    logic [CNT_W-1:0] conf_err_seen = '0;

    // predicted result beats, oldest first
    t_outcome pending_outcomes[$];

    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    // no random idling on either side while set
    logic        steady         = 1'b0;
    // hold-off handshake between the tests and the receiver process
    int unsigned stall_requests = 0;
    int unsigned stall_served   = 0;
    int unsigned stall_left     = 0;

    safety_packet_acceptance_check u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_packet_kind     (pkt_drv.packet_kind),
        .i_checksum_ok     (pkt_drv.checksum_ok),
        .i_sender          (pkt_drv.sender),
        .i_receiver        (pkt_drv.receiver),
        .i_pkt_seq         (pkt_drv.pkt_seq),
        .i_pkt_conf_seq    (pkt_drv.pkt_conf_seq),
        .i_pkt_conf_time   (pkt_drv.pkt_conf_time),
        .i_expected_seq    (pkt_drv.expected_seq),
        .i_last_conf_seq   (pkt_drv.last_conf_seq),
        .i_next_send_seq   (pkt_drv.next_send_seq),
        .i_last_conf_time  (pkt_drv.last_conf_time),
        .i_clear_counts    (pkt_drv.clear_counts),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_verdict         (verdict),
        .o_ids_ok          (ids_ok),
        .o_seq_range_ok    (seq_range_ok),
        .o_conf_seq_ok     (conf_seq_ok),
        .o_seq_in_order    (seq_in_order),
        .o_time_in_order   (time_in_order),
        .o_all_ok          (all_ok),
        .o_checksum_errors (checksum_errors),
        .o_address_errors  (address_errors),
        .o_seq_errors      (seq_errors),
        .o_conf_seq_errors (conf_seq_errors)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // expected result beat for one header; advances the shadow counters
    function automatic t_outcome judge_packet(input t_pkt p);
        t_outcome          r;
        logic [SEQ_W-1:0]  seq_gap;
        logic [SEQ_W-1:0]  conf_gap;
        logic [SEQ_W-1:0]  conf_span;
        logic [SEQ_W-1:0]  last_sent;
        logic [TIME_W-1:0] time_gap;
        logic [63:0]       range_limit;
        r = '0;
        // clear lands before this header's own increment
        if (p.clear_counts) begin
            csum_err_seen = '0;
            addr_err_seen = '0;
            seq_err_seen  = '0;
            conf_err_seen = '0;
        end

        r.chk.ids_ok = (p.sender == cfg_model.peer_id) && (p.receiver == cfg_model.local_id);

        seq_gap     = p.pkt_seq - p.expected_seq;
        range_limit = 64'(cfg_model.send_window) * 64'(RANGE_FACTOR);
        if (p.packet_kind == KIND_CONNREQ || p.packet_kind == KIND_CONNRESP ||
            p.packet_kind == KIND_RETRRESP) begin
            r.chk.seq_range_ok = 1'b1;
        end else begin
            r.chk.seq_range_ok = (p.pkt_seq >= p.expected_seq) && (64'(seq_gap) <= range_limit);
        end

        last_sent = p.next_send_seq - 1'b1;
        conf_gap  = p.pkt_conf_seq - p.last_conf_seq;
        conf_span = p.next_send_seq - p.last_conf_seq;
        if (p.packet_kind == KIND_CONNREQ) begin
            r.chk.conf_seq_ok = (p.pkt_conf_seq == '0);
        end else if (p.packet_kind == KIND_CONNRESP) begin
            r.chk.conf_seq_ok = (p.pkt_conf_seq == last_sent);
        end else begin
            r.chk.conf_seq_ok = (p.pkt_conf_seq >= p.last_conf_seq) && (conf_gap < conf_span);
        end

        // strict ordering only for retransmit request, heartbeat and data kinds
        if (p.packet_kind == KIND_RETRREQ || p.packet_kind >= KIND_HEARTBEAT) begin
            r.chk.seq_in_order = (p.pkt_seq == p.expected_seq);
        end else begin
            r.chk.seq_in_order = 1'b1;
        end

        // timestamp test only for heartbeat and data, skipped before the first one
        time_gap = p.pkt_conf_time - p.last_conf_time;
        if (p.packet_kind >= KIND_HEARTBEAT && p.last_conf_time != '0) begin
            r.chk.time_in_order = (p.pkt_conf_time >= p.last_conf_time) &&
                                  (time_gap < cfg_model.max_delay);
        end else begin
            r.chk.time_in_order = 1'b1;
        end

        r.chk.all_ok = p.checksum_ok && r.chk.ids_ok && r.chk.seq_range_ok &&
                       r.chk.conf_seq_ok && r.chk.seq_in_order && r.chk.time_in_order;

        // first failing check wins; connection request and response kinds skip the checks
        if (p.packet_kind == KIND_CONNREQ) begin
            r.chk.verdict = VERD_CONNREQ;
        end else if (p.packet_kind == KIND_CONNRESP) begin
            r.chk.verdict = VERD_CONNRESP;
        end else if (!p.checksum_ok) begin
            r.chk.verdict = VERD_CHECKSUM;
            csum_err_seen = bump(csum_err_seen);
        end else if (!r.chk.ids_ok) begin
            r.chk.verdict = VERD_ADDRESS;
            addr_err_seen = bump(addr_err_seen);
        end else if (!r.chk.seq_range_ok) begin
            r.chk.verdict = VERD_SEQ;
            seq_err_seen = bump(seq_err_seen);
        end else if (!r.chk.conf_seq_ok) begin
            r.chk.verdict = VERD_CONF_SEQ;
            conf_err_seen = bump(conf_err_seen);
        end else begin
            r.chk.verdict = VERD_ACCEPT;
        end

        r.checksum_errors = csum_err_seen;
        r.address_errors  = addr_err_seen;
        r.seq_errors      = seq_err_seen;
        r.conf_seq_errors = conf_err_seen;
        return r;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LOCAL_ID:    cfg_model.local_id    = data;
            CFG_PEER_ID:     cfg_model.peer_id     = data;
            CFG_MAX_DELAY:   cfg_model.max_delay   = data;
            CFG_SEND_WINDOW: cfg_model.send_window = data[WIN_W-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got %h, predicted %h at %0t ns", what, got, want, $time);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // one process for both sides so a pop and a push at the same edge stay ordered
    always @(posedge clk) begin : scoreboard
        t_outcome want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result beat with nothing pending", {29'd0, verdict}, '0);
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("verdict",         32'(verdict),
                              32'(want.chk.verdict));
                compare_field("ids_ok",          32'(ids_ok),
                              32'(want.chk.ids_ok));
                compare_field("seq_range_ok",    32'(seq_range_ok),
                              32'(want.chk.seq_range_ok));
                compare_field("conf_seq_ok",     32'(conf_seq_ok),
                              32'(want.chk.conf_seq_ok));
                compare_field("seq_in_order",    32'(seq_in_order),
                              32'(want.chk.seq_in_order));
                compare_field("time_in_order",   32'(time_in_order),
                              32'(want.chk.time_in_order));
                compare_field("all_ok",          32'(all_ok),
                              32'(want.chk.all_ok));
                compare_field("checksum_errors", checksum_errors, want.checksum_errors);
                compare_field("address_errors",  address_errors,  want.address_errors);
                compare_field("seq_errors",      seq_errors,      want.seq_errors);
                compare_field("conf_seq_errors", conf_seq_errors, want.conf_seq_errors);
            end
        end
        // header beat accepted: predict its result
        if (rst_n && in_valid && in_ready)
            pending_outcomes.push_back(judge_packet(pkt_drv));
    end

    // hang detection: any beat on any channel restarts the count
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver

    // random stalls, or a long hold-off when a test asks for one
    always @(negedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_requests) begin
            out_ready    <= 1'b0;
            stall_left   <= STALL_CYCLES;
            stall_served <= stall_served + 1;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_packet(input t_pkt p);
        @(negedge clk);
        // random gaps before the beat
        while (!steady && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pkt_drv  <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // window register gets junk in the unused upper half
    task automatic set_config(input t_cfg c);
        write_reg(CFG_LOCAL_ID,    c.local_id);
        write_reg(CFG_PEER_ID,     c.peer_id);
        write_reg(CFG_MAX_DELAY,   c.max_delay);
        write_reg(CFG_SEND_WINDOW, {16'($urandom), c.send_window});
    endtask

    // stop offering and wait until every predicted beat has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- stimulus

    // header that passes every check under the current registers while the max delay is not zero
    function automatic t_pkt coherent_packet(input logic [KIND_W-1:0] kind);
        t_pkt        p;
        logic [31:0] gap;
        logic [31:0] span;
        p.packet_kind   = kind;
        p.checksum_ok   = 1'b1;
        p.sender        = cfg_model.peer_id;
        p.receiver      = cfg_model.local_id;
        p.expected_seq  = $urandom_range(32'hFFF0_0000, 0);
        p.pkt_seq       = p.expected_seq;
        p.last_conf_seq = $urandom_range(32'hFFFF_0000, 0);
        gap             = $urandom_range(64, 1);
        p.next_send_seq = p.last_conf_seq + gap;
        p.pkt_conf_seq  = p.last_conf_seq + $urandom_range(gap - 1, 0);
        if (kind == KIND_CONNREQ)
            p.pkt_conf_seq = '0;
        if (kind == KIND_CONNRESP)
            p.pkt_conf_seq = p.next_send_seq - 1'b1;
        span = (cfg_model.max_delay == '0) ? '0 : cfg_model.max_delay - 1'b1;
        if (span > 32'h0FFF_FFFF)
            span = 32'h0FFF_FFFF;
        // no timestamp seen yet now and then
        p.last_conf_time = ($urandom_range(7) == 0) ? '0 : $urandom_range(32'hEFFF_FFFF, 1);
        p.pkt_conf_time  = p.last_conf_time + $urandom_range(span, 0);
        p.clear_counts   = ($urandom_range(49) == 0);
        return p;
    endfunction

    // mostly well-formed headers with one flaw at most, some pure noise
    function automatic t_pkt random_packet();
        t_pkt        p;
        logic [31:0] lim;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            p.packet_kind    = 3'($urandom);
            p.checksum_ok    = 1'($urandom);
            p.sender         = $urandom;
            p.receiver       = $urandom;
            p.pkt_seq        = $urandom;
            p.pkt_conf_seq   = $urandom;
            p.pkt_conf_time  = $urandom;
            p.expected_seq   = $urandom;
            p.last_conf_seq  = $urandom;
            p.next_send_seq  = $urandom;
            p.last_conf_time = $urandom;
            p.clear_counts   = ($urandom_range(29) == 0);
            return p;
        end
        p    = coherent_packet(3'($urandom));
        lim  = 32'(cfg_model.send_window) * RANGE_FACTOR;
        roll = $urandom_range(99);
        if (roll < 8) begin
            p.checksum_ok = 1'b0;
        end else if (roll < 16) begin
            if ($urandom_range(1))
                p.sender[$urandom_range(ID_W-1)] ^= 1'b1;
            else
                p.receiver[$urandom_range(ID_W-1)] ^= 1'b1;
        end else if (roll < 24) begin
            // just past either end of the range
            if ($urandom_range(1))
                p.pkt_seq = p.expected_seq + lim + $urandom_range(8, 1);
            else
                p.pkt_seq = p.expected_seq - $urandom_range(8, 1);
        end else if (roll < 32) begin
            // inside the range, upper edge included
            p.pkt_seq = p.expected_seq + ($urandom_range(1) ? lim : $urandom_range(lim, 0));
        end else if (roll < 40) begin
            if ($urandom_range(1))
                p.pkt_conf_seq = p.next_send_seq;
            else
                p.pkt_conf_seq = p.last_conf_seq - $urandom_range(4, 1);
        end else if (roll < 48) begin
            if (p.last_conf_time == '0)
                p.last_conf_time = $urandom_range(32'hEFFF_FFFF, 1);
            if ($urandom_range(1))
                p.pkt_conf_time = p.last_conf_time + cfg_model.max_delay;
            else
                p.pkt_conf_time = p.last_conf_time - 1'b1;
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- tests

    // reset register values, one header per kind and each corner of the checks
    task automatic test_directed_cases();
        t_pkt        p;
        logic [31:0] lim;
        lim = 32'(cfg_model.send_window) * RANGE_FACTOR;
        for (int k = KIND_CONNREQ; k <= KIND_RETRDATA; k++) begin
            p = coherent_packet(3'(k));
            p.clear_counts = 1'b0;
            send_packet(p);
        end
        // handoffs ignore a bad checksum and bad ids, counters stay put
        p = coherent_packet(KIND_CONNREQ);
        p.pkt_conf_seq = 32'd5;
        p.checksum_ok  = 1'b0;
        p.sender       = ~cfg_model.peer_id;
        p.clear_counts = 1'b0;
        send_packet(p);
        p = coherent_packet(KIND_CONNRESP);
        p.pkt_conf_seq = p.next_send_seq;
        p.clear_counts = 1'b0;
        send_packet(p);
        // checksum failure, then address failures on the sender and on the receiver
        p = coherent_packet(KIND_DATA);
        p.checksum_ok  = 1'b0;
        p.clear_counts = 1'b0;
        send_packet(p);
        p = coherent_packet(KIND_DATA);
        p.sender       = ~cfg_model.peer_id;
        p.clear_counts = 1'b0;
        send_packet(p);
        p = coherent_packet(KIND_HEARTBEAT);
        p.receiver     = cfg_model.local_id ^ 32'h8000_0000;
        p.clear_counts = 1'b0;
        send_packet(p);
        // upper edge of the range passes, one more fails, one below fails
        p = coherent_packet(KIND_RETRREQ);
        p.pkt_seq      = p.expected_seq + lim;
        p.clear_counts = 1'b0;
        send_packet(p);
        p.packet_kind = KIND_DATA;
        p.pkt_seq     = p.expected_seq + lim + 1'b1;
        send_packet(p);
        p.pkt_seq = p.expected_seq - 1'b1;
        send_packet(p);
        // confirmed sequence equal to next send, then below the last one
        p = coherent_packet(KIND_DATA);
        p.pkt_conf_seq = p.next_send_seq;
        p.clear_counts = 1'b0;
        send_packet(p);
        p.packet_kind  = KIND_DISCREQ;
        p.pkt_conf_seq = p.last_conf_seq - 1'b1;
        send_packet(p);
        // timestamp just inside, on and behind the limit: accepted; order flag high just inside, low on and behind
        p = coherent_packet(KIND_DATA);
        p.last_conf_time = 32'd1000;
        p.pkt_conf_time  = p.last_conf_time + cfg_model.max_delay - 1'b1;
        p.clear_counts   = 1'b0;
        send_packet(p);
        p.pkt_conf_time = p.last_conf_time + cfg_model.max_delay;
        send_packet(p);
        p.packet_kind   = KIND_RETRDATA;
        p.pkt_conf_time = p.last_conf_time - 1'b1;
        send_packet(p);
        // first timestamp: anything goes
        p.last_conf_time = '0;
        p.pkt_conf_time  = '1;
        send_packet(p);
        // clear together with a failure leaves the count at one
        p = coherent_packet(KIND_DATA);
        p.checksum_ok  = 1'b0;
        p.clear_counts = 1'b1;
        send_packet(p);
        // all ones, all zeros
        send_packet('1);
        send_packet('0);
        drain_results();
    endtask

    // several register settings, extremes among them, random traffic under each
    task automatic test_register_extremes();
        t_cfg c;
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: c = '{local_id: $urandom, peer_id: $urandom, max_delay: MAX_DELAY_RST,
                         send_window: SEND_WINDOW_RST};
                1: c = '0;
                2: c = '1;
                3: c = '{local_id: $urandom, peer_id: $urandom,
                         max_delay: $urandom_range(5000, 1),
                         send_window: 16'($urandom_range(100, 1))};
                default: c = '{local_id: $urandom, peer_id: $urandom, max_delay: 32'd1,
                               send_window: 16'd1};
            endcase
            set_config(c);
            repeat (150) send_packet(random_packet());
            drain_results();
        end
    endtask

    // writes to indexes past the last register must change nothing
    task automatic test_stray_register_index();
        write_reg(CFG_SEND_WINDOW + 1'b1, $urandom);
        write_reg('1, $urandom);
        repeat (40) send_packet(random_packet());
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_input_backpressure();
        steady = 1'b1;
        stall_requests++;
        repeat (60) send_packet(random_packet());
        steady = 1'b0;
        drain_results();
    endtask

    // back-to-back beats first, then random idling on both sides
    task automatic test_steady_stream();
        t_cfg c;
        c = '{local_id: $urandom, peer_id: $urandom, max_delay: $urandom_range(100000, 1),
              send_window: 16'($urandom)};
        set_config(c);
        steady = 1'b1;
        repeat (150) send_packet(random_packet());
        steady = 1'b0;
        repeat (200) send_packet(random_packet());
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_stray_register_index();
        test_input_backpressure();
        test_steady_stream();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/sapc_pkg.sv
rtl/sapc_check.sv
rtl/safety_packet_acceptance_check.sv
test/tb_safety_packet_acceptance_check.sv
